// ===== hw/rtl/box_blur_bloom_filter_macros.svh =====
// Assertion macros for the box blur bloom filter.
// Used by box_blur_bloom_filter.sv; expects clk and arst_n in the including scope.
`ifndef BOX_BLUR_BLOOM_FILTER_MACROS_SVH
`define BOX_BLUR_BLOOM_FILTER_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define BBB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bbb: property failed");
// Condition that must never be seen outside reset.
`define BBB_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("bbb: forbidden condition seen");
`else
`define BBB_ASSERT(lbl, prop)
`define BBB_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== hw/rtl/bbb_pkg.sv =====
// Types and constants of the box blur bloom filter.
// No dependencies; imported by box_blur_bloom_filter.sv.
package bbb_pkg;

	localparam int CHAN_W     = 8;
	localparam int NCHAN      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int FW_W       = 10;
	localparam int FH_W       = 10;
	localparam int BR_W       = 4;
	localparam int BS_W       = 12;
	localparam int GAIN_FRAC  = 8;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH    = 3'd0,
		CFG_FRAME_HEIGHT   = 3'd1,
		CFG_BLUR_RADIUS    = 3'd2,
		CFG_BLOOM_ENABLE   = 3'd3,
		CFG_BLOOM_STRENGTH = 3'd4
	} cfg_reg_t;

	// Input item kinds.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// One pixel: index 2 is red, 1 is green, 0 is blue.
	typedef logic [NCHAN-1:0][CHAN_W-1:0] rgb_t;

	// Sequencer states.
	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_HSET = 11'b000_0000_0010,
		ST_HRD  = 11'b000_0000_0100,
		ST_HACC = 11'b000_0000_1000,
		ST_HDIV = 11'b000_0001_0000,
		ST_ECHK = 11'b000_0010_0000,
		ST_VRD  = 11'b000_0100_0000,
		ST_VACC = 11'b000_1000_0000,
		ST_VDIV = 11'b001_0000_0000,
		ST_VMUL = 11'b010_0000_0000,
		ST_VOUT = 11'b100_0000_0000
	} state_t;

endpackage

// ===== hw/rtl/box_blur_bloom_filter.sv =====
// Box blur bloom filter: streaming separable box blur, scaled and added to the pixel.
// Depends on bbb_pkg and box_blur_bloom_filter_macros.svh.
//
// Channel | Handshake             | Payload
// in      | in_valid / in_ready   | operation, red_in, green_in, blue_in
// out     | out_valid / out_ready | red_out, green_out, blue_out, last_of_frame
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item is worked on at a time. A pixel is stored, then each horizontal average it
// completes (one column mid row, up to r+1 at the row end) is summed tap by tap and divided,
// then each output it releases is checked, summed, divided, scaled and sent; the single read
// port of the row window and of the line store, one tap per cycle, paces these steps.
// Reset clears counters and loads configuration defaults; line stores are written before they are read.
// A waiting output stalls the final step of the next result, and input requests with it.
`include "box_blur_bloom_filter_macros.svh"

module box_blur_bloom_filter #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int MAX_RADIUS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [bbb_pkg::CHAN_W-1:0]    red_in,
	input  logic [bbb_pkg::CHAN_W-1:0]    green_in,
	input  logic [bbb_pkg::CHAN_W-1:0]    blue_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bbb_pkg::CHAN_W-1:0]    red_out,
	output logic [bbb_pkg::CHAN_W-1:0]    green_out,
	output logic [bbb_pkg::CHAN_W-1:0]    blue_out,
	output logic                          last_of_frame,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bbb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bbb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bbb_pkg::*;

	localparam int TAPS      = 2 * MAX_RADIUS + 1;
	localparam int ORIG_ROWS = MAX_RADIUS + 1;
	localparam int XW        = $clog2(MAX_WIDTH + 1);
	localparam int YW        = $clog2(MAX_HEIGHT + 1);
	localparam int PW        = (XW > YW) ? XW : YW;
	localparam int JW        = PW + 2;
	localparam int RW        = $clog2(MAX_RADIUS + 1);
	localparam int KW        = $clog2(TAPS);
	localparam int TW        = $clog2(TAPS);
	localparam int OW        = (ORIG_ROWS > 1) ? $clog2(ORIG_ROWS) : 1;
	localparam int HB_DEPTH  = TAPS * MAX_WIDTH;
	localparam int OR_DEPTH  = ORIG_ROWS * MAX_WIDTH;
	localparam int HAW       = $clog2(HB_DEPTH);
	localparam int OAW       = $clog2(OR_DEPTH);
	localparam int SUM_W     = $clog2(TAPS * ((1 << CHAN_W) - 1) + 1);
	localparam int SH        = SUM_W + $clog2(TAPS);
	localparam int RCW       = SH;
	localparam int PRW       = CHAN_W + BS_W;

	// Configuration registers.
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic [BR_W-1:0] blur_radius_q;
	logic            bloom_enable_q;
	logic [BS_W-1:0] bloom_strength_q;

	// Control state.
	state_t          state_q;
	logic [PW-1:0]   in_col_q, in_row_q, out_col_q, out_row_q;
	logic [TW-1:0]   in_col_m_q, in_row_mt_q, out_row_mt_q;
	logic [OW-1:0]   in_row_mo_q, out_row_mo_q;
	logic            drain_q;
	logic            out_valid_q;
	logic            rd_vld_s1;

	// Datapath registers.
	logic [PW-1:0]   cur_ix_q, cur_iy_q, hcx_q, hhi_q;
	logic [TW-1:0]   cur_ix_m_q, cur_iy_mt_q, win_m_q;
	logic signed [JW-1:0] j_q;
	logic [KW-1:0]   k_q;
	logic [NCHAN-1:0][SUM_W-1:0] acc_q;
	rgb_t            quot_q;
	logic [NCHAN-1:0][PRW-1:0] prod_q;
	rgb_t            res_q;
	logic            last_q;

	// Memories and their read registers.
	rgb_t            rw_mem [TAPS];
	rgb_t            hb_mem [HB_DEPTH];
	rgb_t            or_mem [OR_DEPTH];
	rgb_t            rw_rd_q, hb_rd_q, or_rd_q;

	// Effective geometry.
	logic [PW-1:0]   w_eff, h_eff, w_m1, h_m1;
	logic [RW-1:0]   r_eff;
	logic [KW-1:0]   k_last;

	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = PW'(1);
		end else if (int'(frame_width_q) > MAX_WIDTH) begin
			w_eff = PW'(MAX_WIDTH);
		end else begin
			w_eff = PW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = PW'(1);
		end else if (int'(frame_height_q) > MAX_HEIGHT) begin
			h_eff = PW'(MAX_HEIGHT);
		end else begin
			h_eff = PW'(frame_height_q);
		end
		if (blur_radius_q == '0) begin
			r_eff = RW'(1);
		end else if (int'(blur_radius_q) > MAX_RADIUS) begin
			r_eff = RW'(MAX_RADIUS);
		end else begin
			r_eff = RW'(blur_radius_q);
		end
	end

	assign w_m1   = w_eff - PW'(1);
	assign h_m1   = h_eff - PW'(1);
	assign k_last = KW'({r_eff, 1'b0});

	// Reciprocals of the tap counts, exact for every possible tap sum.
	logic [RCW-1:0] recip_tab [1:MAX_RADIUS];
	for (genvar g = 1; g <= MAX_RADIUS; g++) begin : g_recip
		localparam int Div      = 2 * g + 1;
		localparam int RecipVal = ((1 << SH) + Div - 1) / Div;
		assign recip_tab[g] = RCW'(RecipVal);
	end

	// Handshakes.
	logic pix_acc, drn_acc, cfg_acc, geo_wr, in_done, out_load, out_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_done   = (in_row_q >= h_eff);
	assign pix_acc   = in_valid && in_ready && (operation == OP_PIXEL) && !in_done;
	assign drn_acc   = in_valid && in_ready && (operation == OP_DRAIN) && in_done
		&& (out_row_q < h_eff);
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign geo_wr    = cfg_acc && ((cfg_index == CFG_FRAME_WIDTH)
		|| (cfg_index == CFG_FRAME_HEIGHT) || (cfg_index == CFG_BLUR_RADIUS));
	assign out_load  = (state_q == ST_VOUT) && (!out_valid_q || out_ready);
	assign out_last  = (out_col_q == w_m1) && (out_row_q == h_m1);

	// Horizontal columns completed by the incoming pixel.
	logic          col_mid, col_ge_r, h_any;
	logic [PW-1:0] col_mr, h_lo;

	always_comb begin
		col_mid  = (in_col_q < w_m1);
		col_ge_r = (in_col_q >= PW'(r_eff));
		col_mr   = in_col_q - PW'(r_eff);
		h_any    = !col_mid || col_ge_r;
		h_lo     = col_ge_r ? col_mr : '0;
	end

	// Start of a tap window: first clamped position and its slot in the circular store.
	logic [PW-1:0]        win_base, win_ref, win_p0, win_d;
	logic [TW-1:0]        win_ref_m, win_dt, win_m0;
	logic signed [JW-1:0] win_j0;

	always_comb begin
		if (state_q == ST_HSET) begin
			win_base  = hcx_q;
			win_ref   = cur_ix_q;
			win_ref_m = cur_ix_m_q;
		end else begin
			win_base  = out_row_q;
			win_ref   = out_row_q;
			win_ref_m = out_row_mt_q;
		end
		win_j0 = $signed({2'b00, win_base}) - $signed({{(JW - RW){1'b0}}, r_eff});
		win_p0 = win_j0[JW-1] ? '0 : win_j0[PW-1:0];
		win_d  = win_ref - win_p0;
		win_dt = TW'(win_d);
		if (win_ref_m >= win_dt) begin
			win_m0 = win_ref_m - win_dt;
		end else begin
			win_m0 = win_ref_m + TW'(TAPS) - win_dt;
		end
	end

	// Tap stepping: the clamped position moves only while inside the line.
	logic signed [JW-1:0] j_next, j_lim;
	logic                 win_step;

	always_comb begin
		j_next   = j_q + JW'(1);
		j_lim    = (state_q == ST_HRD) ? $signed({2'b00, w_m1}) : $signed({2'b00, h_m1});
		win_step = (j_next > $signed(JW'(0))) && (j_next <= j_lim);
	end

	// Emission check for a pixel item.
	logic [PW:0]   oy_r, ox_r;
	logic [PW-1:0] ox_min;
	logic          emit_ok;

	always_comb begin
		oy_r    = {1'b0, out_row_q} + (PW + 1)'(r_eff);
		ox_r    = {1'b0, out_col_q} + (PW + 1)'(r_eff);
		ox_min  = (ox_r > {1'b0, w_m1}) ? w_m1 : ox_r[PW-1:0];
		emit_ok = (oy_r == {1'b0, cur_iy_q}) && (ox_min <= cur_ix_q);
	end

	// Tap source and divide by the tap count.
	rgb_t                             tap_src, dq;
	logic [NCHAN-1:0][SUM_W+RCW-1:0]  dprod;
	logic [RCW-1:0]                   recip;

	assign tap_src = ((state_q == ST_HRD) || (state_q == ST_HACC)) ? rw_rd_q : hb_rd_q;
	assign recip   = recip_tab[r_eff];

	always_comb begin
		for (int c = 0; c < NCHAN; c++) begin
			dprod[c] = (SUM_W + RCW)'(acc_q[c]) * (SUM_W + RCW)'(recip);
			dq[c]    = dprod[c][SH +: CHAN_W];
		end
	end

	// Glow rounding, add and saturation.
	rgb_t bloom_res;
	logic [NCHAN-1:0][PRW-1:0] glow;
	logic [NCHAN-1:0][PRW:0]   gsum;

	always_comb begin
		for (int c = 0; c < NCHAN; c++) begin
			glow[c] = (prod_q[c] + PRW'(1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
			gsum[c] = (PRW + 1)'(glow[c]) + (PRW + 1)'(or_rd_q[c]);
			if (gsum[c] > (PRW + 1)'((1 << CHAN_W) - 1)) begin
				bloom_res[c] = '1;
			end else begin
				bloom_res[c] = gsum[c][CHAN_W-1:0];
			end
		end
	end

	// Memory addresses.
	logic [HAW-1:0] hb_waddr, hb_raddr;
	logic [OAW-1:0] or_waddr, or_raddr;

	assign hb_waddr = HAW'(cur_iy_mt_q) * HAW'(MAX_WIDTH) + HAW'(hcx_q);
	assign hb_raddr = HAW'(win_m_q) * HAW'(MAX_WIDTH) + HAW'(out_col_q);
	assign or_waddr = OAW'(in_row_mo_q) * OAW'(MAX_WIDTH) + OAW'(in_col_q);
	assign or_raddr = OAW'(out_row_mo_q) * OAW'(MAX_WIDTH) + OAW'(out_col_q);

	// Row window of the current line.
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			rw_mem[in_col_m_q] <= {red_in, green_in, blue_in};
		end
		rw_rd_q <= rw_mem[win_m_q];
	end

	// Line store of horizontal averages.
	always_ff @(posedge clk) begin
		if (state_q == ST_HDIV) begin
			hb_mem[hb_waddr] <= dq;
		end
		hb_rd_q <= hb_mem[hb_raddr];
	end

	// Line store of original pixels.
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			or_mem[or_waddr] <= {red_in, green_in, blue_in};
		end
		or_rd_q <= or_mem[or_raddr];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= FW_W'(64);
			frame_height_q   <= FH_W'(32);
			blur_radius_q    <= BR_W'(3);
			bloom_enable_q   <= 1'b0;
			bloom_strength_q <= '0;
		end else if (cfg_acc) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:    frame_width_q    <= cfg_data[FW_W-1:0];
				CFG_FRAME_HEIGHT:   frame_height_q   <= cfg_data[FH_W-1:0];
				CFG_BLUR_RADIUS:    blur_radius_q    <= cfg_data[BR_W-1:0];
				CFG_BLOOM_ENABLE:   bloom_enable_q   <= cfg_data[0];
				CFG_BLOOM_STRENGTH: bloom_strength_q <= cfg_data[BS_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, position counters and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			in_col_q     <= '0;
			in_row_q     <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			in_col_m_q   <= '0;
			in_row_mt_q  <= '0;
			in_row_mo_q  <= '0;
			out_row_mt_q <= '0;
			out_row_mo_q <= '0;
			drain_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			rd_vld_s1    <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_HRD) || (state_q == ST_VRD);
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (pix_acc) begin
						drain_q <= 1'b0;
						state_q <= h_any ? ST_HSET : ST_ECHK;
					end else if (drn_acc) begin
						drain_q <= 1'b1;
						state_q <= ST_ECHK;
					end
				end
				ST_HSET: state_q <= ST_HRD;
				ST_HRD: begin
					if (k_q == k_last) begin
						state_q <= ST_HACC;
					end
				end
				ST_HACC: state_q <= ST_HDIV;
				ST_HDIV: state_q <= (hcx_q == hhi_q) ? ST_ECHK : ST_HSET;
				ST_ECHK: state_q <= (drain_q || emit_ok) ? ST_VRD : ST_IDLE;
				ST_VRD: begin
					if (k_q == k_last) begin
						state_q <= ST_VACC;
					end
				end
				ST_VACC: state_q <= ST_VDIV;
				ST_VDIV: state_q <= ST_VMUL;
				ST_VMUL: state_q <= ST_VOUT;
				ST_VOUT: begin
					if (out_load) begin
						state_q <= (drain_q || out_last) ? ST_IDLE : ST_ECHK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// Geometry writes and the end of a frame restart every counter.
			if (geo_wr || (out_load && out_last)) begin
				in_col_q     <= '0;
				in_row_q     <= '0;
				out_col_q    <= '0;
				out_row_q    <= '0;
				in_col_m_q   <= '0;
				in_row_mt_q  <= '0;
				in_row_mo_q  <= '0;
				out_row_mt_q <= '0;
				out_row_mo_q <= '0;
			end else begin
				if (pix_acc) begin
					if (in_col_q == w_m1) begin
						in_col_q    <= '0;
						in_col_m_q  <= '0;
						in_row_q    <= in_row_q + PW'(1);
						in_row_mt_q <= (in_row_mt_q == TW'(TAPS - 1)) ? '0
							: in_row_mt_q + TW'(1);
						in_row_mo_q <= (in_row_mo_q == OW'(ORIG_ROWS - 1)) ? '0
							: in_row_mo_q + OW'(1);
					end else begin
						in_col_q   <= in_col_q + PW'(1);
						in_col_m_q <= (in_col_m_q == TW'(TAPS - 1)) ? '0
							: in_col_m_q + TW'(1);
					end
				end
				if (out_load) begin
					if (out_col_q == w_m1) begin
						out_col_q    <= '0;
						out_row_q    <= out_row_q + PW'(1);
						out_row_mt_q <= (out_row_mt_q == TW'(TAPS - 1)) ? '0
							: out_row_mt_q + TW'(1);
						out_row_mo_q <= (out_row_mo_q == OW'(ORIG_ROWS - 1)) ? '0
							: out_row_mo_q + OW'(1);
					end else begin
						out_col_q <= out_col_q + PW'(1);
					end
				end
			end
		end
	end

	// Item context, tap window walk, sums and result stages.
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			cur_ix_q    <= in_col_q;
			cur_iy_q    <= in_row_q;
			cur_ix_m_q  <= in_col_m_q;
			cur_iy_mt_q <= in_row_mt_q;
			hcx_q       <= h_lo;
			hhi_q       <= in_col_q == w_m1 ? in_col_q : col_mr;
		end

		if ((state_q == ST_HSET) || (state_q == ST_ECHK)) begin
			j_q     <= win_j0;
			k_q     <= '0;
			win_m_q <= win_m0;
		end else if ((state_q == ST_HRD) || (state_q == ST_VRD)) begin
			j_q <= j_next;
			k_q <= k_q + KW'(1);
			if (win_step) begin
				win_m_q <= (win_m_q == TW'(TAPS - 1)) ? '0 : win_m_q + TW'(1);
			end
		end

		if ((state_q == ST_HDIV) && (hcx_q != hhi_q)) begin
			hcx_q <= hcx_q + PW'(1);
		end

		// Tap accumulation, one tap per cycle behind the memory read.
		for (int c = 0; c < NCHAN; c++) begin
			if (rd_vld_s1) begin
				acc_q[c] <= acc_q[c] + SUM_W'(tap_src[c]);
			end else if ((state_q != ST_HRD) && (state_q != ST_VRD)) begin
				acc_q[c] <= '0;
			end
		end

		if (state_q == ST_VDIV) begin
			quot_q <= dq;
		end
		if (state_q == ST_VMUL) begin
			for (int c = 0; c < NCHAN; c++) begin
				prod_q[c] <= PRW'(quot_q[c]) * PRW'(bloom_strength_q);
			end
		end
		if (out_load) begin
			res_q  <= bloom_enable_q ? bloom_res : or_rd_q;
			last_q <= out_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign red_out       = res_q[2];
	assign green_out     = res_q[1];
	assign blue_out      = res_q[0];
	assign last_of_frame = last_q;

	// Tap data is only summed while a window is being read.
	`BBB_ASSERT(a_tap_in_window, rd_vld_s1 |-> (state_q == ST_HRD || state_q == ST_HACC || state_q == ST_VRD || state_q == ST_VACC))
	// Output rows never run ahead of input rows.
	`BBB_ASSERT_NEVER(a_out_behind_in, out_row_q > in_row_q)
	// The final pixel of a frame restarts the frame.
	`BBB_ASSERT(a_frame_restart, out_load && out_last |=> (in_row_q == '0 && out_row_q == '0))
	// A pixel request after the frame's last input leaves the position unchanged.
	`BBB_ASSERT(a_drop_late_pixel, in_valid && in_ready && operation == OP_PIXEL && in_done && !cfg_valid |=> $stable(in_row_q) && $stable(in_col_q))

endmodule
